/* hdl/rapc_pkg.sv */
// Shared types and constants for the array-of-bulk-strings request parser.
// Used by every module of the parser; depends on nothing else.
`timescale 1ns / 1ps

package rapc_pkg;

    localparam int MAX_ARGS_DEF = 64;
    localparam int LEN_BITS_DEF = 32;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NOT_STAR  = 3'd1;
    localparam logic [2:0] ERR_NOT_DOLLAR = 3'd2;
    localparam logic [2:0] ERR_BAD_DEC   = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
    localparam logic [2:0] ERR_ZERO_CNT  = 3'd5;
    localparam logic [2:0] ERR_NO_CRLF   = 3'd6;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [5:0] arg_index;
        logic       arg_last;
        logic       command_done;
        logic [2:0] error_code;
    } rapc_result_t;

endpackage

/* hdl/resp_array_command_parser.sv */
// Top level of the array-of-bulk-strings request parser: input register, parser, result register.
// Depends on rapc_pkg, rapc_fsm (with rapc_digit) and rapc_out_stage.
//
//   Channel  Direction  Handshake          Word contents
//   s_       in         s_valid/s_ready    s_in_byte: one request byte
//   m_       out        m_valid/m_ready    kind, data_byte, arg_index, arg_last,
//                                          command_done, error_code
//
// One byte is taken per cycle while the result register can load; each byte is held in the
// input register until the parser takes it, and its result, if any, is loaded into the result register as it is taken.
// The parser state updates once per byte taken, which sets the one-byte rate.
// Synchronous active-low reset clears all control state and returns the parser to idle.
// A stalled result stalls the input only while both the result and input registers are full.
`timescale 1ns / 1ps

module resp_array_command_parser import rapc_pkg::*; #(
    parameter int MAX_ARGS = MAX_ARGS_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [5:0] m_arg_index,
    output logic       m_arg_last,
    output logic       m_command_done,
    output logic [2:0] m_error_code
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         can_load;
    logic         fire;
    logic         res_valid;
    rapc_result_t res;
    rapc_result_t m_data;

    assign fire    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    rapc_fsm #(
        .MAX_ARGS (MAX_ARGS),
        .LEN_BITS (LEN_BITS)
    ) u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    rapc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && res_valid),
        .load_data (res),
        .m_ready   (m_ready),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    assign m_kind         = m_data.kind;
    assign m_data_byte    = m_data.data_byte;
    assign m_arg_index    = m_data.arg_index;
    assign m_arg_last     = m_data.arg_last;
    assign m_command_done = m_data.command_done;
    assign m_error_code   = m_data.error_code;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_DATA) |-> (m_data_byte == 8'd0) && !m_arg_last)
        else $error("Non-data word carries payload fields.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == KIND_ERROR) == (m_error_code != ERR_NONE)))
        else $error("Error code does not match word kind.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command_done |-> (m_kind == KIND_CLOSED))
        else $error("Command done set on a word that does not close an argument.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !can_load |=> in_valid_reg && $stable(in_byte_reg))
        else $error("Input register lost a byte while the parser was stalled.");

endmodule

/* hdl/rapc_digit.sv */
// One decimal digit step: accumulator times ten plus the digit, with a limit check.
// Uses constants from rapc_pkg.
`timescale 1ns / 1ps

module rapc_digit import rapc_pkg::*; #(
    parameter int ACC_W = 32
) (
    input  logic [7:0]       in_byte,
    input  logic [ACC_W-1:0] acc,
    input  logic [ACC_W-1:0] limit,
    output logic             is_digit,
    output logic             over,
    output logic [ACC_W-1:0] acc_out
);

    logic [ACC_W+3:0] acc_wide;
    logic [ACC_W+3:0] prod;
    logic [7:0]       digit;

    assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign digit    = in_byte - CHAR_ZERO;
    assign acc_wide = {4'b0000, acc};
    assign prod     = (acc_wide << 3) + (acc_wide << 1) + {{(ACC_W - 4){1'b0}}, digit};
    assign over     = prod > {4'b0000, limit};
    assign acc_out  = prod[ACC_W-1:0];

endmodule

/* hdl/rapc_fsm.sv */
// Parser state machine: phase, number accumulator, argument counters and result decode.
// Uses rapc_pkg and instantiates rapc_digit.
`timescale 1ns / 1ps

module rapc_fsm import rapc_pkg::*; #(
    parameter int MAX_ARGS = MAX_ARGS_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         fire,
    input  logic [7:0]   in_byte,
    output logic         res_valid,
    output rapc_result_t res
);

    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int ARG_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int ACC_W = (LEN_BITS > CNT_W) ? LEN_BITS : CNT_W;
    localparam logic [ACC_W-1:0] CNT_LIMIT = ACC_W'(MAX_ARGS);
    localparam logic [ACC_W-1:0] LEN_LIMIT = ACC_W'((64'd1 << LEN_BITS) - 64'd1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CNT_NUM,
        PH_CNT_LF,
        PH_BULK,
        PH_LEN_NUM,
        PH_LEN_LF,
        PH_PAYLOAD,
        PH_TR_CR,
        PH_TR_LF
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                seen_reg, seen_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [ARG_W-1:0]    cur_reg, cur_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;

    logic             is_digit;
    logic             over;
    logic [ACC_W-1:0] dig_acc;
    logic [ACC_W-1:0] limit;
    logic             fail;
    logic [2:0]       fail_code;
    logic [ARG_W+5:0] arg_ext;
    logic [CNT_W:0]   arg_plus;
    logic             done;
    logic [LEN_BITS-1:0] rem_dec;
    logic [7:0]       lower_byte;

    assign limit    = (phase_reg == PH_CNT_NUM) ? CNT_LIMIT : LEN_LIMIT;
    assign arg_ext  = {6'b000000, cur_reg};
    assign arg_plus = (CNT_W + 1)'(cur_reg) + 1'b1;
    assign done     = arg_plus >= {1'b0, total_reg};
    assign rem_dec  = rem_reg - 1'b1;
    assign lower_byte = ((cur_reg == '0) && (in_byte >= CHAR_UPPER_A) &&
                         (in_byte <= CHAR_UPPER_Z)) ? (in_byte + CASE_OFFSET) : in_byte;

    rapc_digit #(
        .ACC_W (ACC_W)
    ) u_digit (
        .in_byte  (in_byte),
        .acc      (acc_reg),
        .limit    (limit),
        .is_digit (is_digit),
        .over     (over),
        .acc_out  (dig_acc)
    );

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        total_next = total_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        fail       = 1'b0;
        fail_code  = ERR_NONE;
        res_valid  = 1'b0;
        res              = '0;
        res.arg_index    = arg_ext[5:0];
        case (phase_reg)
            PH_CNT_NUM, PH_LEN_NUM: begin
                if (is_digit) begin
                    acc_next  = dig_acc;
                    seen_next = 1'b1;
                    if (over) begin
                        fail      = 1'b1;
                        fail_code = ERR_TOO_LARGE;
                    end
                end else if ((in_byte == CHAR_CR) && seen_reg) begin
                    if (phase_reg == PH_LEN_NUM) begin
                        phase_next = PH_LEN_LF;
                    end else if (acc_reg == '0) begin
                        fail      = 1'b1;
                        fail_code = ERR_ZERO_CNT;
                    end else begin
                        total_next = acc_reg[CNT_W-1:0];
                        phase_next = PH_CNT_LF;
                    end
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_BAD_DEC;
                end
            end
            PH_CNT_LF: begin
                if (in_byte != CHAR_LF) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_CRLF;
                end else begin
                    cur_next   = '0;
                    phase_next = PH_BULK;
                end
            end
            PH_LEN_LF: begin
                if (in_byte != CHAR_LF) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_CRLF;
                end else begin
                    rem_next   = acc_reg[LEN_BITS-1:0];
                    phase_next = (acc_reg == '0) ? PH_TR_CR : PH_PAYLOAD;
                end
            end
            PH_BULK: begin
                if (in_byte != CHAR_DOLLAR) begin
                    fail      = 1'b1;
                    fail_code = ERR_NOT_DOLLAR;
                end else begin
                    acc_next   = '0;
                    seen_next  = 1'b0;
                    phase_next = PH_LEN_NUM;
                end
            end
            PH_PAYLOAD: begin
                rem_next      = rem_dec;
                res_valid     = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = lower_byte;
                res.arg_last  = (rem_dec == '0);
                if (rem_dec == '0) begin
                    phase_next = PH_TR_CR;
                end
            end
            PH_TR_CR: begin
                if (in_byte != CHAR_CR) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_CRLF;
                end else begin
                    phase_next = PH_TR_LF;
                end
            end
            PH_TR_LF: begin
                if (in_byte != CHAR_LF) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_CRLF;
                end else begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_CLOSED;
                    res.command_done = done;
                    if (done) begin
                        phase_next = PH_IDLE;
                        acc_next   = '0;
                        seen_next  = 1'b0;
                        total_next = '0;
                        cur_next   = '0;
                        rem_next   = '0;
                    end else begin
                        cur_next   = cur_reg + 1'b1;
                        phase_next = PH_BULK;
                    end
                end
            end
            default: begin
                acc_next   = '0;
                seen_next  = 1'b0;
                total_next = '0;
                cur_next   = '0;
                rem_next   = '0;
                if (in_byte != CHAR_STAR) begin
                    fail      = 1'b1;
                    fail_code = ERR_NOT_STAR;
                end else begin
                    phase_next = PH_CNT_NUM;
                end
            end
        endcase
        if (fail) begin
            phase_next       = PH_IDLE;
            acc_next         = '0;
            seen_next        = 1'b0;
            total_next       = '0;
            cur_next         = '0;
            rem_next         = '0;
            res_valid        = 1'b1;
            res.kind         = KIND_ERROR;
            res.data_byte    = '0;
            res.arg_last     = 1'b0;
            res.command_done = 1'b0;
            res.error_code   = fail_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            total_reg <= '0;
            cur_reg   <= '0;
            rem_reg   <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            total_reg <= total_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

/* hdl/rapc_out_stage.sv */
// Result register with valid and ready toward the result channel.
// Uses rapc_result_t from rapc_pkg.
`timescale 1ns / 1ps

module rapc_out_stage import rapc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  rapc_result_t load_data,
    input  logic         m_ready,
    output logic         can_load,
    output logic         m_valid,
    output rapc_result_t m_data
);

    logic         valid_reg, valid_next;
    rapc_result_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

/* tb/resp_array_command_parser_tb.sv */
// Self-checking testbench for resp_array_command_parser: streams request bytes through the
// parser and checks every result word against an untimed predictor held in a class.
// Depends on rapc_pkg and the resp_array_command_parser RTL.
`timescale 1ns / 1ps

import rapc_pkg::*;

typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT,
    ST_COUNT_LF,
    ST_BULK,
    ST_LEN,
    ST_LEN_LF,
    ST_PAYLOAD,
    ST_TRAIL_CR,
    ST_TRAIL_LF
} parse_phase_t;

class parser_scoreboard;
    rapc_result_t expected_words[$];
    int           failures;
    parse_phase_t phase;
    logic [39:0]  acc;
    bit           digit_seen;
    logic [6:0]   args_total;
    logic [5:0]   cur_arg;
    logic [31:0]  remaining;

    function new();
        failures = 0;
        clear_state();
    endfunction

    function void clear_state();
        phase      = ST_IDLE;
        acc        = '0;
        digit_seen = 1'b0;
        args_total = '0;
        cur_arg    = '0;
        remaining  = '0;
    endfunction

    function rapc_result_t abort(input logic [2:0] code);
        rapc_result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.arg_index  = cur_arg;
        r.error_code = code;
        clear_state();
        return r;
    endfunction

    function logic [2:0] number_byte(input logic [7:0] b, input logic [39:0] limit,
                                     output bit at_cr);
        at_cr = 1'b0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            acc        = acc * 10 + (b - CHAR_ZERO);
            digit_seen = 1'b1;
            return (acc > limit) ? ERR_TOO_LARGE : ERR_NONE;
        end
        if (b == CHAR_CR && digit_seen) begin
            at_cr = 1'b1;
            return ERR_NONE;
        end
        return ERR_BAD_DEC;
    endfunction

    function bit parse_byte(input logic [7:0] b, output rapc_result_t r);
        logic [2:0] code;
        bit         at_cr;
        bit         done;
        r           = '0;
        r.arg_index = cur_arg;
        case (phase)
            ST_COUNT: begin
                code = number_byte(b, 40'(MAX_ARGS_DEF), at_cr);
                if (code != ERR_NONE) begin
                    r = abort(code);
                    return 1'b1;
                end
                if (at_cr) begin
                    if (acc == 0) begin
                        r = abort(ERR_ZERO_CNT);
                        return 1'b1;
                    end
                    args_total = acc[6:0];
                    phase      = ST_COUNT_LF;
                end
                return 1'b0;
            end
            ST_COUNT_LF, ST_LEN_LF: begin
                if (b != CHAR_LF) begin
                    r = abort(ERR_NO_CRLF);
                    return 1'b1;
                end
                if (phase == ST_COUNT_LF) begin
                    cur_arg = '0;
                    phase   = ST_BULK;
                end else begin
                    remaining = acc[31:0];
                    phase     = (remaining != 0) ? ST_PAYLOAD : ST_TRAIL_CR;
                end
                return 1'b0;
            end
            ST_BULK: begin
                if (b != CHAR_DOLLAR) begin
                    r = abort(ERR_NOT_DOLLAR);
                    return 1'b1;
                end
                acc        = '0;
                digit_seen = 1'b0;
                phase      = ST_LEN;
                return 1'b0;
            end
            ST_LEN: begin
                code = number_byte(b, (40'd1 << LEN_BITS_DEF) - 40'd1, at_cr);
                if (code != ERR_NONE) begin
                    r = abort(code);
                    return 1'b1;
                end
                if (at_cr) begin
                    phase = ST_LEN_LF;
                end
                return 1'b0;
            end
            ST_PAYLOAD: begin
                r.kind      = KIND_DATA;
                r.data_byte = b;
                if (cur_arg == 0 && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
                    r.data_byte = b + CASE_OFFSET;
                end
                remaining  = remaining - 32'd1;
                r.arg_last = (remaining == 0);
                if (remaining == 0) begin
                    phase = ST_TRAIL_CR;
                end
                return 1'b1;
            end
            ST_TRAIL_CR: begin
                if (b != CHAR_CR) begin
                    r = abort(ERR_NO_CRLF);
                    return 1'b1;
                end
                phase = ST_TRAIL_LF;
                return 1'b0;
            end
            ST_TRAIL_LF: begin
                if (b != CHAR_LF) begin
                    r = abort(ERR_NO_CRLF);
                    return 1'b1;
                end
                done           = (({1'b0, cur_arg} + 7'd1) >= args_total);
                r.kind         = KIND_CLOSED;
                r.command_done = done;
                if (done) begin
                    clear_state();
                end else begin
                    cur_arg = cur_arg + 6'd1;
                    phase   = ST_BULK;
                end
                return 1'b1;
            end
            default: begin
                clear_state();
                if (b != CHAR_STAR) begin
                    r = abort(ERR_NOT_STAR);
                    return 1'b1;
                end
                phase = ST_COUNT;
                return 1'b0;
            end
        endcase
    endfunction

    function void note_byte(input logic [7:0] b);
        rapc_result_t r;
        if (parse_byte(b, r)) begin
            expected_words.insert(expected_words.size(), r);
        end
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(input rapc_result_t got);
        rapc_result_t want;
        if (expected_words.size() == 0) begin
            $error("result word with nothing expected: kind %0d error_code %0d",
                   got.kind, got.error_code);
            failures++;
            return;
        end
        want = expected_words[0];
        expected_words.delete(0);
        compare_field("kind", want.kind, got.kind);
        compare_field("data_byte", want.data_byte, got.data_byte);
        compare_field("arg_index", want.arg_index, got.arg_index);
        compare_field("arg_last", want.arg_last, got.arg_last);
        compare_field("command_done", want.command_done, got.command_done);
        compare_field("error_code", want.error_code, got.error_code);
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module resp_array_command_parser_tb;

    localparam int ITEM_TARGET  = 1850;
    localparam int CALM_TAIL    = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_data_byte;
    logic [5:0] m_arg_index;
    logic       m_arg_last;
    logic       m_command_done;
    logic [2:0] m_error_code;

    parser_scoreboard parser_sb;
    logic [7:0]       req_bytes[$];
    int               sent_bytes = 0;
    int               stall_cycles = 0;
    bit               s_gaps_on = 1'b1;
    bit               m_gaps_on = 1'b1;
    bit               hold_off_req = 1'b0;

    resp_array_command_parser uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_arg_index    (m_arg_index),
        .m_arg_last     (m_arg_last),
        .m_command_done (m_command_done),
        .m_error_code   (m_error_code)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void append_byte(input logic [7:0] b);
        req_bytes.insert(req_bytes.size(), b);
    endfunction

    function automatic void push_text(input string s);
        foreach (s[i]) begin
            append_byte(s[i]);
        end
    endfunction

    function automatic void push_number(input longint unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 2)) append_byte(CHAR_ZERO);
        end
        push_text(s);
    endfunction

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 3))
            0: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
            1: return CHAR_UPPER_A + CASE_OFFSET + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] fault_byte();
        case ($urandom_range(0, 5))
            0: return CHAR_CR;
            1: return CHAR_LF;
            2: return CHAR_DOLLAR;
            3: return CHAR_STAR;
            4: return "-";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_command(input int n_args, input int max_len);
        int len;
        append_byte(CHAR_STAR);
        push_number(n_args);
        push_text("\r\n");
        for (int a = 0; a < n_args; a++) begin
            len = $urandom_range(0, max_len);
            append_byte(CHAR_DOLLAR);
            push_number(len);
            push_text("\r\n");
            repeat (len) append_byte(payload_byte());
            push_text("\r\n");
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        if (s_gaps_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parser_sb.note_byte(b);
        sent_bytes++;
    endtask

    task automatic flush_requests();
        foreach (req_bytes[i]) begin
            send_byte(req_bytes[i]);
        end
        req_bytes.delete();
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (m_gaps_on && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            parser_sb.check_result('{m_kind, m_data_byte, m_arg_index, m_arg_last,
                                     m_command_done, m_error_code});
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("resp_array_command_parser verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned cut;
        int          cmd_idx;
        parser_sb = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = 8'h00;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        append_byte(8'hFF);
        push_text("*0\r");
        push_text("*+");
        push_text("*65");
        push_text("*2\r\n$0\r\n\r\n#");
        push_text("*1\r\n$1\r\nZ\rx");
        flush_requests();

        cmd_idx = 0;
        while (sent_bytes < ITEM_TARGET) begin
            if (sent_bytes >= ITEM_TARGET - CALM_TAIL) begin
                s_gaps_on = 1'b0;
                m_gaps_on = 1'b0;
            end
            if (cmd_idx == 12) begin
                hold_off_req = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (cmd_idx == 0) begin
                build_command(MAX_ARGS_DEF, 2);
            end else if (pick < 78) begin
                build_command($urandom_range(1, 5), ($urandom_range(0, 9) == 0) ? 40 : 8);
            end else if (pick < 90) begin
                build_command($urandom_range(1, 4), 8);
                cut = $urandom_range(0, req_bytes.size() - 1);
                while (req_bytes.size() > cut) req_bytes.delete(req_bytes.size() - 1);
                append_byte(fault_byte());
            end else if (pick < 95) begin
                push_text("*1\r\n$");
                case ($urandom_range(0, 2))
                    0: push_text("4294967296");
                    1: push_text("4294967295x");
                    default: push_text("0004294967295\r\r");
                endcase
            end else begin
                repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
            end
            flush_requests();
            cmd_idx++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (parser_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (parser_sb.failures == 0) begin
            $display("resp_array_command_parser verification clean");
        end else begin
            $display("resp_array_command_parser verification failed");
        end
        $finish;
    end

endmodule
